### hw/rtl/fpr_pkg.sv
// Shared types and constants for the FIFO page replacement block.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package fpr_pkg;

	// Fixed field widths of the channels and the configuration register.
	localparam int PAGE_ID_W   = 16;
	localparam int PAGE_SIZE_W = 16;
	localparam int TOTAL_W     = 32;
	localparam int LIMIT_W     = 4;
	localparam int RESIDENT_W  = 4;

	// Frame limit after reset.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	// Saturation value of the running totals.
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MISS,
		ST_EVICT,
		ST_TRIM,
		ST_DONE
	} fpr_state_t;

endpackage

### hw/rtl/fpr_if.sv
// Valid/ready channel interfaces for page references and their results.
// Depends on fpr_pkg for the field widths.
`timescale 1ns / 1ps

interface fpr_req_if;
	logic                             valid;
	logic                             ready;
	logic [fpr_pkg::PAGE_ID_W-1:0]    page_id;
	logic [fpr_pkg::PAGE_SIZE_W-1:0]  page_size;

	modport source (output valid, output page_id, output page_size, input ready);
	modport sink   (input valid, input page_id, input page_size, output ready);
endinterface

interface fpr_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             hit;
	logic                             evicted;
	logic [fpr_pkg::PAGE_ID_W-1:0]    evicted_id;
	logic [fpr_pkg::RESIDENT_W-1:0]   resident_count;
	logic [fpr_pkg::TOTAL_W-1:0]      hit_total;
	logic [fpr_pkg::TOTAL_W-1:0]      miss_total;
	logic [fpr_pkg::TOTAL_W-1:0]      access_count;

	modport source (output valid, output hit, output evicted, output evicted_id,
		output resident_count, output hit_total, output miss_total,
		output access_count, input ready);
	modport sink   (input valid, input hit, input evicted, input evicted_id,
		input resident_count, input hit_total, input miss_total,
		input access_count, output ready);
endinterface

### hw/rtl/fifo_page_replacement_core.sv
// FIFO page replacement core: one reference in, one result out.
// A hit ends the ring scan at the matching page; a miss scans every resident page,
// then evicts the oldest page when the ring holds as many pages as the limit, drops
// further pages after the limit was lowered, and loads the new page into the ring.
// A new reference is accepted only in idle, after the one-compare scan and the result load.
// Reset clears the totals, occupancy and ring pointer and sets the limit to 8.
`timescale 1ns / 1ps

module fifo_page_replacement_core #(
	parameter int FRAMES   = 8,
	parameter int ID_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fpr_pkg::LIMIT_W-1:0]   cfg_wdata,
	fpr_req_if.sink                       req,
	fpr_rsp_if.source                     rsp
);

	import fpr_pkg::*;

	localparam int AW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int OCW = $clog2(FRAMES + 1);

	// Ring pointer advance with wrap at the frame count.
	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		return (p == AW'(FRAMES - 1)) ? '0 : p + AW'(1);
	endfunction

	fpr_state_t                state_q, state_d;

	logic [LIMIT_W-1:0]        frame_limit_q;
	logic [OCW-1:0]            occ_q;
	logic [AW-1:0]             oldest_q;
	logic [TOTAL_W-1:0]        hit_sum_q, miss_sum_q, ref_count_q;

	logic [ID_WIDTH-1:0]       id_q;
	logic [PAGE_SIZE_W-1:0]    size_q;
	logic [AW-1:0]             rd_ptr_q;
	logic [OCW-1:0]            iss_cnt_q;
	logic                      chk_vld_q;
	logic                      hit_q, evicted_q;
	logic [PAGE_ID_W-1:0]      evicted_id_q;

	logic                      out_vld_q;

	logic [OCW-1:0]            lim;
	logic                      match;
	logic                      ram_re, ram_we;
	logic [AW-1:0]             ram_raddr;
	logic [ID_WIDTH-1:0]       ram_rdata;
	logic [AW:0]               load_sum;
	logic [AW-1:0]             load_slot;
	logic [TOTAL_W:0]          acc_sum;
	logic [TOTAL_W-1:0]        acc_sat;
	logic [TOTAL_W-1:0]        ref_next;
	logic                      out_load;

	// Effective limit: zero acts as one, anything above the frame count is clipped.
	always_comb begin
		if (frame_limit_q == '0) begin
			lim = OCW'(1);
		end else if (int'(frame_limit_q) > FRAMES) begin
			lim = OCW'(FRAMES);
		end else begin
			lim = OCW'(frame_limit_q);
		end
	end

	// Shared compare unit: stored page against the current reference.
	assign match = chk_vld_q && (ram_rdata == id_q);

	// Slot that receives a newly loaded page, one compare-and-subtract wrap.
	assign load_sum  = {1'b0, oldest_q} + (AW + 1)'(occ_q);
	assign load_slot = (load_sum >= (AW + 1)'(FRAMES)) ?
		AW'(load_sum - (AW + 1)'(FRAMES)) : AW'(load_sum);

	// Saturating accumulator shared by the hit and miss totals.
	assign acc_sum = {1'b0, (state_q == ST_MISS) ? miss_sum_q : hit_sum_q}
		+ (TOTAL_W + 1)'(size_q);
	assign acc_sat = acc_sum[TOTAL_W] ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];

	assign ref_next = (ref_count_q == TOTAL_MAX) ? TOTAL_MAX : ref_count_q + TOTAL_W'(1);

	assign out_load  = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = out_vld_q;

	// Next state and RAM control.
	always_comb begin
		state_d   = state_q;
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q;
		ram_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (match) begin
					state_d = ST_DONE;
				end else if (iss_cnt_q < occ_q) begin
					ram_re = 1'b1;
				end else begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				if (occ_q >= lim) begin
					ram_re    = 1'b1;
					ram_raddr = oldest_q;
					state_d   = ST_EVICT;
				end else begin
					state_d = ST_TRIM;
				end
			end
			ST_EVICT: begin
				state_d = ST_TRIM;
			end
			ST_TRIM: begin
				if (occ_q < lim) begin
					ram_we  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: limit, ring, totals, search bookkeeping and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= LIMIT_RESET;
			occ_q         <= '0;
			oldest_q      <= '0;
			hit_sum_q     <= '0;
			miss_sum_q    <= '0;
			ref_count_q   <= '0;
			chk_vld_q     <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_limit_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					chk_vld_q <= 1'b0;
				end
				ST_SEARCH: begin
					chk_vld_q <= ram_re;
					if (match) begin
						hit_sum_q <= acc_sat;
					end
				end
				ST_MISS: begin
					miss_sum_q <= acc_sat;
				end
				ST_EVICT: begin
					oldest_q <= next_slot(oldest_q);
					occ_q    <= occ_q - OCW'(1);
				end
				ST_TRIM: begin
					if (occ_q >= lim) begin
						oldest_q <= next_slot(oldest_q);
						occ_q    <= occ_q - OCW'(1);
					end else begin
						occ_q <= occ_q + OCW'(1);
					end
				end
				ST_DONE: begin
					if (out_load) begin
						ref_count_q <= ref_next;
					end
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Per-reference payload registers and the result beat.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					id_q         <= ID_WIDTH'(req.page_id);
					size_q       <= req.page_size;
					rd_ptr_q     <= oldest_q;
					iss_cnt_q    <= '0;
					hit_q        <= 1'b0;
					evicted_q    <= 1'b0;
					evicted_id_q <= '0;
				end
			end
			ST_SEARCH: begin
				if (ram_re) begin
					rd_ptr_q  <= next_slot(rd_ptr_q);
					iss_cnt_q <= iss_cnt_q + OCW'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			ST_EVICT: begin
				evicted_q    <= 1'b1;
				evicted_id_q <= PAGE_ID_W'(ram_rdata);
			end
			ST_DONE: begin
				if (out_load) begin
					rsp.hit            <= hit_q;
					rsp.evicted        <= evicted_q;
					rsp.evicted_id     <= evicted_id_q;
					rsp.resident_count <= RESIDENT_W'(occ_q);
					rsp.hit_total      <= hit_sum_q;
					rsp.miss_total     <= miss_sum_q;
					rsp.access_count   <= ref_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Page ring storage.
	fpr_ram #(
		.WIDTH (ID_WIDTH),
		.DEPTH (FRAMES)
	) u_frames (
		.clk   (clk),
		.we    (ram_we),
		.waddr (load_slot),
		.wdata (id_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

### hw/rtl/fpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module fpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; contents have no reset.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
